// ----- hdl/debounced_stopwatch_threshold_alarm_core_assert.svh -----
// Assertion macros used by the stopwatch alarm RTL.
`ifndef DEBOUNCED_STOPWATCH_THRESHOLD_ALARM_CORE_ASSERT_SVH
`define DEBOUNCED_STOPWATCH_THRESHOLD_ALARM_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsta same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DSTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsta next-cycle check failed");

`endif

// ----- hdl/dsta_pkg.sv -----
// Package: types, constants and lookup functions of the stopwatch alarm.
package dsta_pkg;

    localparam int unsigned SEC_W   = 7;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned BLINK_W = 10;
    localparam int unsigned DEB_W   = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [SEC_W-1:0]   SEC_MAX         = 7'd99;
    localparam logic [SEC_W-1:0]   LIMIT_RESET     = 7'd10;
    localparam logic [DEB_W-1:0]   DEB_RESET       = 8'd20;
    localparam logic [BLINK_W-1:0] BLINK_RESET     = 10'd250;
    localparam logic [TICK_W-1:0]  TPS_RESET       = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS   = 2'd0,
        CFG_BLINK_TICKS      = 2'd1,
        CFG_TICKS_PER_SECOND = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_KEY  = 1'b1
    } command_t;

    typedef struct packed {
        logic [SEC_W-1:0] elapsed_seconds;
        logic             is_timing;
        logic             alarm_active;
        logic             alarm_lamp_on;
        logic             switch_lamp_on;
        logic [SEC_W-1:0] limit_seconds;
        logic [1:0]       digits_entered;
        logic [6:0]       seg_ones;
        logic [6:0]       seg_tens;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] digit;
    } key_t;

    // Keypad scan code to decimal digit.
    function automatic key_t key_decode(input logic [7:0] code);
        key_t k;
        k.hit   = 1'b1;
        k.digit = 4'd0;
        unique case (code)
            8'h82:   k.digit = 4'd0;
            8'h11:   k.digit = 4'd1;
            8'h12:   k.digit = 4'd2;
            8'h14:   k.digit = 4'd3;
            8'h21:   k.digit = 4'd4;
            8'h22:   k.digit = 4'd5;
            8'h24:   k.digit = 4'd6;
            8'h41:   k.digit = 4'd7;
            8'h42:   k.digit = 4'd8;
            8'h44:   k.digit = 4'd9;
            default: k.hit   = 1'b0;
        endcase
        return k;
    endfunction

    // Active-low seven-segment pattern of one decimal digit.
    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h40;
            4'd1:    s = 7'h79;
            4'd2:    s = 7'h24;
            4'd3:    s = 7'h30;
            4'd4:    s = 7'h19;
            4'd5:    s = 7'h12;
            4'd6:    s = 7'h02;
            4'd7:    s = 7'h78;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h18;
            default: s = 7'h7F;
        endcase
        return s;
    endfunction

endpackage

// ----- hdl/dsta_if.sv -----
// Interfaces: item, result and configuration channels.
interface dsta_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic       switch_raw;
    logic [7:0] scan_code;

    modport source (output valid, command, switch_raw, scan_code, input ready);
    modport sink   (input valid, command, switch_raw, scan_code, output ready);
endinterface

interface dsta_result_if;
    logic                          valid;
    logic                          ready;
    logic [dsta_pkg::SEC_W-1:0]    elapsed_seconds;
    logic                          is_timing;
    logic                          alarm_active;
    logic                          alarm_lamp_on;
    logic                          switch_lamp_on;
    logic [dsta_pkg::SEC_W-1:0]    limit_seconds;
    logic [1:0]                    digits_entered;
    logic [6:0]                    seg_ones;
    logic [6:0]                    seg_tens;

    modport source (output valid, elapsed_seconds, is_timing, alarm_active, alarm_lamp_on,
                    switch_lamp_on, limit_seconds, digits_entered, seg_ones, seg_tens,
                    input ready);
    modport sink   (input valid, elapsed_seconds, is_timing, alarm_active, alarm_lamp_on,
                    switch_lamp_on, limit_seconds, digits_entered, seg_ones, seg_tens,
                    output ready);
endinterface

interface dsta_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dsta_pkg::CFG_IDX_W-1:0]    index;
    logic [dsta_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/dsta_seg_dec.sv -----
// Seconds (0..99) to active-low seven-segment patterns of both digits.
module dsta_seg_dec (
    input  logic [dsta_pkg::SEC_W-1:0] secs,
    output logic [6:0]                 seg_ones,
    output logic [6:0]                 seg_tens
);

    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones_full;

    // tens = secs / 10 through multiply by 205 and shift by 11, exact below 100
    assign prod      = 15'(secs) * 15'd205;
    assign tens      = prod[14:11];
    assign tens_x10  = {tens, 3'b000} - 7'({tens, 1'b0}) + 7'({tens, 2'b00});
    assign ones_full = secs - tens_x10;

    assign seg_ones = dsta_pkg::seg_pattern(ones_full[3:0]);
    assign seg_tens = dsta_pkg::seg_pattern(tens);

endmodule

// ----- hdl/debounced_stopwatch_threshold_alarm_core.sv -----
// Top level: debounced stopwatch with keyed-in threshold alarm.
//
//  channel  | role   | beat contents
//  ---------+--------+----------------------------------------------------
//  item     | sink   | command, switch_raw, scan_code
//  result   | source | seconds, timing/alarm/lamp flags, limit, digits, segs
//  cfg      | sink   | index, data (debounce, blink, ticks per second)
//
//  Each accepted item is handled in the cycle it arrives: the state update and
//  the result are computed from the beat and the state registers and land in
//  the state and result registers at the same edge. One item per cycle unless a stalled result holds it.
//  The result register takes a new beat whenever it is empty or being drained,
//  so a stalled result blocks input only while it is still held.
//  Reset restores all state but the result payload; config is ready every cycle.
`include "debounced_stopwatch_threshold_alarm_core_assert.svh"

module debounced_stopwatch_threshold_alarm_core (
    input  logic          clk,
    input  logic          rst_n,
    dsta_item_if.sink     item,
    dsta_result_if.source result,
    dsta_cfg_if.sink      cfg
);

    // Configuration registers
    logic [dsta_pkg::DEB_W-1:0]   deb_ticks_reg;
    logic [dsta_pkg::BLINK_W-1:0] blink_ticks_reg;
    logic [dsta_pkg::TICK_W-1:0]  tps_reg;

    // Block state
    logic                          last_sample_reg,  last_sample_next;
    logic                          stable_level_reg, stable_level_next;
    logic [dsta_pkg::DEB_W-1:0]    stable_count_reg, stable_count_next;
    logic [dsta_pkg::TICK_W-1:0]   tick_count_reg,   tick_count_next;
    logic [dsta_pkg::SEC_W-1:0]    second_count_reg, second_count_next;
    logic                          running_reg,      running_next;
    logic                          alarm_flag_reg,   alarm_flag_next;
    logic [dsta_pkg::BLINK_W-1:0]  blink_count_reg,  blink_count_next;
    logic                          lamp_lit_reg,     lamp_lit_next;
    logic [dsta_pkg::SEC_W-1:0]    limit_reg,        limit_next;
    logic [1:0]                    digit_total_reg,  digit_total_next;
    logic [3:0]                    first_digit_reg,  first_digit_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    dsta_pkg::result_t    rslt_reg,      rslt_next;

    logic                 accept;
    logic                 edge_seen;
    logic                 second_done;
    dsta_pkg::key_t       key;
    logic [dsta_pkg::SEC_W-1:0] keyed_value;
    logic [6:0]           seg_ones_w;
    logic [6:0]           seg_tens_w;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // Config writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_ticks_reg   <= dsta_pkg::DEB_RESET;
            blink_ticks_reg <= dsta_pkg::BLINK_RESET;
            tps_reg         <= dsta_pkg::TPS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                dsta_pkg::CFG_DEBOUNCE_TICKS:
                    deb_ticks_reg <= cfg.data[dsta_pkg::DEB_W-1:0];
                dsta_pkg::CFG_BLINK_TICKS:
                    blink_ticks_reg <= cfg.data[dsta_pkg::BLINK_W-1:0];
                dsta_pkg::CFG_TICKS_PER_SECOND:
                    tps_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign key         = dsta_pkg::key_decode(item.scan_code);
    // first*10 + digit; first is at most 9, so this stays below 100
    assign keyed_value = 7'({first_digit_reg, 3'b000}) + 7'({first_digit_reg, 1'b0})
                       + 7'(key.digit);

    // One item; a tick is applied in order: debounce, edge, count, threshold, blink; else key entry
    always_comb
    begin
        last_sample_next  = last_sample_reg;
        stable_level_next = stable_level_reg;
        stable_count_next = stable_count_reg;
        tick_count_next   = tick_count_reg;
        second_count_next = second_count_reg;
        running_next      = running_reg;
        alarm_flag_next   = alarm_flag_reg;
        blink_count_next  = blink_count_reg;
        lamp_lit_next     = lamp_lit_reg;
        limit_next        = limit_reg;
        digit_total_next  = digit_total_reg;
        first_digit_next  = first_digit_reg;
        edge_seen         = 1'b0;
        second_done       = 1'b0;

        if (item.command == dsta_pkg::CMD_TICK)
        begin
            // Debounce: a changed sample restarts the stability count
            priority if (item.switch_raw != last_sample_reg)
            begin
                last_sample_next  = item.switch_raw;
                stable_count_next = '0;
            end
            else if (stable_count_reg < deb_ticks_reg)
            begin
                stable_count_next = stable_count_reg + 8'd1;
            end
            else if (stable_level_reg != last_sample_reg)
            begin
                stable_level_next = last_sample_reg;
                edge_seen         = 1'b1;
            end
            else
            begin
                // Settled and unchanged: hold the debounce state
            end

            // Edge actions: rise starts timing, fall stops it and drops digits
            if (edge_seen)
            begin
                running_next    = stable_level_next;
                alarm_flag_next = 1'b0;
                lamp_lit_next   = 1'b0;
                if (stable_level_next)
                begin
                    tick_count_next   = '0;
                    second_count_next = '0;
                end
                else
                begin
                    digit_total_next = '0;
                    first_digit_next = '0;
                end
            end

            // Advance the tick and second counters; seconds hold at 99
            if (running_next)
            begin
                tick_count_next = tick_count_next + 16'd1;
                if (tick_count_next >= tps_reg)
                begin
                    tick_count_next = '0;
                    if (second_count_next < dsta_pkg::SEC_MAX)
                    begin
                        second_count_next = second_count_next + 7'd1;
                    end
                    second_done = 1'b1;
                end
            end

            // Threshold check on a completed second
            if (second_done)
            begin
                if (running_next && (second_count_next >= limit_reg))
                begin
                    if (!alarm_flag_next)
                    begin
                        alarm_flag_next  = 1'b1;
                        blink_count_next = '0;
                        lamp_lit_next    = 1'b1;
                    end
                end
                else
                begin
                    alarm_flag_next = 1'b0;
                    lamp_lit_next   = 1'b0;
                end
            end

            // Blink the lamp while the alarm holds
            if (alarm_flag_next)
            begin
                blink_count_next = blink_count_next + 10'd1;
                if (blink_count_next >= blink_ticks_reg)
                begin
                    blink_count_next = '0;
                    lamp_lit_next    = !lamp_lit_next;
                end
            end
            else
            begin
                lamp_lit_next = 1'b0;
            end
        end
        else
        begin
            // Key press: the first digit is held, the second sets the limit
            if (key.hit)
            begin
                if (digit_total_reg == 2'd0)
                begin
                    first_digit_next = key.digit;
                    digit_total_next = 2'd1;
                end
                else if (digit_total_reg == 2'd1)
                begin
                    limit_next       = (keyed_value == '0) ? 7'd1 : keyed_value;
                    digit_total_next = 2'd2;
                end
            end
        end
    end

    dsta_seg_dec u_seg_dec (
        .secs     (second_count_next),
        .seg_ones (seg_ones_w),
        .seg_tens (seg_tens_w)
    );

    always_comb
    begin
        rslt_next.elapsed_seconds = second_count_next;
        rslt_next.is_timing       = running_next;
        rslt_next.alarm_active    = alarm_flag_next;
        rslt_next.alarm_lamp_on   = lamp_lit_next;
        rslt_next.switch_lamp_on  = stable_level_next;
        rslt_next.limit_seconds   = limit_next;
        rslt_next.digits_entered  = digit_total_next;
        rslt_next.seg_ones        = seg_ones_w;
        rslt_next.seg_tens        = seg_tens_w;
        out_valid_next            = accept || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg  <= 1'b0;
            stable_level_reg <= 1'b0;
            stable_count_reg <= '0;
            tick_count_reg   <= '0;
            second_count_reg <= '0;
            running_reg      <= 1'b0;
            alarm_flag_reg   <= 1'b0;
            blink_count_reg  <= '0;
            lamp_lit_reg     <= 1'b0;
            limit_reg        <= dsta_pkg::LIMIT_RESET;
            digit_total_reg  <= '0;
            first_digit_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                last_sample_reg  <= last_sample_next;
                stable_level_reg <= stable_level_next;
                stable_count_reg <= stable_count_next;
                tick_count_reg   <= tick_count_next;
                second_count_reg <= second_count_next;
                running_reg      <= running_next;
                alarm_flag_reg   <= alarm_flag_next;
                blink_count_reg  <= blink_count_next;
                lamp_lit_reg     <= lamp_lit_next;
                limit_reg        <= limit_next;
                digit_total_reg  <= digit_total_next;
                first_digit_reg  <= first_digit_next;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rslt_reg <= rslt_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.elapsed_seconds = rslt_reg.elapsed_seconds;
    assign result.is_timing       = rslt_reg.is_timing;
    assign result.alarm_active    = rslt_reg.alarm_active;
    assign result.alarm_lamp_on   = rslt_reg.alarm_lamp_on;
    assign result.switch_lamp_on  = rslt_reg.switch_lamp_on;
    assign result.limit_seconds   = rslt_reg.limit_seconds;
    assign result.digits_entered  = rslt_reg.digits_entered;
    assign result.seg_ones        = rslt_reg.seg_ones;
    assign result.seg_tens        = rslt_reg.seg_tens;

    `DSTA_ASSERT_NOW(a_sec_sat, clk, rst_n, 1'b1, second_count_reg <= dsta_pkg::SEC_MAX)
    `DSTA_ASSERT_NOW(a_limit_rng, clk, rst_n, 1'b1,
        (limit_reg >= 7'd1) && (limit_reg <= dsta_pkg::SEC_MAX))
    `DSTA_ASSERT_NOW(a_lamp_alarm, clk, rst_n, lamp_lit_reg, alarm_flag_reg && running_reg)
    `DSTA_ASSERT_NEXT(a_accept_out, clk, rst_n, accept, out_valid_reg)

endmodule
